[src/hdse_pkg.sv]
// package: types, constants and codes for the spectrum encoder
`default_nettype none
package hdse_pkg;
    localparam int MAX_WORDS  = 64;
    localparam int MAX_LEVELS = 64;
    localparam int ID_BINS    = 1024;
    localparam int WIX_W      = 6;
    localparam int LVL_W      = 6;
    localparam int BIN_W      = 10;
    localparam int CNT_W      = 7;
    localparam int QD_W       = 2;
    localparam int QDEPTH     = 4;

    localparam logic [1:0] CMD_LOAD_LEVEL = 2'd0;
    localparam logic [1:0] CMD_LOAD_ID    = 2'd1;
    localparam logic [1:0] CMD_PEAK       = 2'd2;
    localparam logic [1:0] CMD_FINISH     = 2'd3;

    localparam logic [1:0] CFG_LEVELS    = 2'd0;
    localparam logic [1:0] CFG_BIN_WIDTH = 2'd1;
    localparam logic [1:0] CFG_WORDS     = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [9:0]         table_index;
        logic [5:0]         word_index;
        logic [31:0]        word_data;
        logic [31:0]        mz;
        logic signed [31:0] intensity;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  out_index;
        logic [31:0] out_word;
        logic        last;
    } t_out_item;

    // classified job handed from front to back
    typedef struct packed {
        logic             finish;
        logic [LVL_W-1:0] lvl;
        logic [BIN_W-1:0] bin;
    } t_job;
endpackage
`default_nettype wire

[src/hdse_front.sv]
// front: accepts items, handles loads, quantizes peaks, queues jobs
`default_nettype none
module hdse_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire hdse_pkg::t_in_item    i_item,
    output logic                       o_busy,
    input  wire logic [5:0]            i_levels,
    input  wire logic [10:0]           i_bin_width,
    input  wire logic                  i_tables_busy,
    output logic                       o_lwe,
    output logic                       o_iwe,
    output logic [15:0]                o_waddr,
    output logic [31:0]                o_wdata,
    output logic                       o_job_valid,
    output hdse_pkg::t_job             o_job,
    input  wire logic                  i_job_full
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_PUSH = 3'd3;

    logic [2:0]  r_state, n_state;
    logic [31:0] r_mag;
    logic        r_neg;
    logic [37:0] r_prod;
    logic [15:0] r_quo, r_rem_src;
    logic [11:0] r_rem;
    logic [4:0]  r_cnt;
    logic [10:0] r_bw;
    logic        r_skip;
    logic [5:0]  r_lvl;
    logic        r_finish;

    logic        acc;
    logic [31:0] in_raw;
    logic [11:0] trial;
    logic [37:0] q;
    logic        is_load;
    logic        drop;

    assign in_raw  = i_item.intensity;
    assign is_load = (i_item.cmd == hdse_pkg::CMD_LOAD_LEVEL) ||
                     (i_item.cmd == hdse_pkg::CMD_LOAD_ID);
    assign acc     = i_start && !o_busy;
    // a load waits until no queued or walking peak can still read the tables
    assign o_busy  = (r_state != S_IDLE) || (i_tables_busy && is_load);
    assign q       = r_prod >> 16;
    assign trial   = {r_rem[10:0], r_rem_src[15]} ;
    assign drop    = r_skip || (!r_finish && r_quo[15:10] != 6'd0);

    always_comb begin
        o_lwe   = acc && i_item.cmd == hdse_pkg::CMD_LOAD_LEVEL && i_item.table_index < 10'd64;
        o_iwe   = acc && i_item.cmd == hdse_pkg::CMD_LOAD_ID;
        o_waddr = {i_item.table_index, i_item.word_index};
        o_wdata = i_item.word_data;
        o_job_valid = (r_state == S_PUSH) && !i_job_full && !drop;
        o_job.finish = r_finish;
        o_job.lvl    = r_lvl;
        o_job.bin    = r_quo[9:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc && i_item.cmd == hdse_pkg::CMD_PEAK) n_state = S_MUL;
                else if (acc && i_item.cmd == hdse_pkg::CMD_FINISH) n_state = S_PUSH;
            end
            S_MUL: n_state = S_DIV;
            S_DIV: if (r_cnt == 5'd15) n_state = S_PUSH;
            S_PUSH: if (!i_job_full || drop) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        case (r_state)
            S_IDLE: begin
                r_neg     <= in_raw[31];
                r_mag     <= in_raw[31] ? (~in_raw + 32'd1) : in_raw;
                r_rem_src <= i_item.mz[31:16];
                r_bw      <= (i_bin_width == 11'd0) ? 11'd1 : i_bin_width;
                r_rem     <= 12'd0;
                r_quo     <= 16'd0;
                r_cnt     <= 5'd0;
                r_skip    <= 1'b0;
                r_lvl     <= 6'd0;
                r_finish  <= (i_item.cmd == hdse_pkg::CMD_FINISH);
                r_prod    <= 38'd0;
            end
            S_MUL: begin
                r_prod <= 38'(r_mag * i_levels);
            end
            S_DIV: begin
                if (r_cnt == 5'd0) begin
                    if (r_neg && q != 38'd0) r_skip <= 1'b1;
                    r_lvl <= (q > 38'(i_levels)) ? i_levels : q[5:0];
                end
                if (trial >= {1'b0, r_bw}) begin
                    r_rem <= trial - {1'b0, r_bw};
                    r_quo <= {r_quo[14:0], 1'b1};
                end else begin
                    r_rem <= trial;
                    r_quo <= {r_quo[14:0], 1'b0};
                end
                r_rem_src <= {r_rem_src[14:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

[src/hdse_queue.sv]
// small job queue between front and back
`default_nettype none
module hdse_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire hdse_pkg::t_job i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output hdse_pkg::t_job      o_data
);
    hdse_pkg::t_job r_mem [hdse_pkg::QDEPTH];
    logic [hdse_pkg::QD_W-1:0] r_wp, r_rp;
    logic [hdse_pkg::QD_W:0]   r_cnt;

    assign o_full  = (r_cnt == 3'(hdse_pkg::QDEPTH));
    assign o_empty = (r_cnt == 3'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (i_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

[src/hdse_back.sv]
// back: table memories, accumulator walk and result emission
`default_nettype none
module hdse_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_lwe,
    input  wire logic             i_iwe,
    input  wire logic [15:0]      i_waddr,
    input  wire logic [31:0]      i_wdata,
    input  wire logic [6:0]       i_words,
    input  wire logic             i_empty,
    input  wire hdse_pkg::t_job   i_job,
    output logic                  o_pop,
    output logic                  o_tables_busy,
    output logic                  o_valid,
    output hdse_pkg::t_out_item   o_item
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PEAK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [31:0] r_lmem [4096];
    logic [31:0] r_imem [65536];
    logic [31:0] r_acc  [64];
    logic [63:0] r_accv;

    logic [1:0]  r_state;
    logic [6:0]  r_j, r_n;
    logic [5:0]  r_lvl;
    logic [9:0]  r_bin;
    logic [31:0] r_ld, r_id, r_ad;
    logic        r_rv;
    logic [5:0]  r_rj;
    logic        r_ovalid;
    hdse_pkg::t_out_item r_oitem;
    logic [6:0]  nw;

    assign nw      = (i_words > 7'd64) ? 7'd64 : i_words;
    assign o_pop   = (r_state == S_IDLE) && !i_empty && !r_rv;
    assign o_tables_busy = !i_empty || (r_state == S_PEAK);
    assign o_valid = r_ovalid;
    assign o_item  = r_oitem;

    always_ff @(posedge i_clk) begin
        if (i_lwe) r_lmem[i_waddr[11:0]] <= i_wdata;
        if (i_iwe) r_imem[i_waddr] <= i_wdata;
        r_ld <= r_lmem[{r_lvl, r_j[5:0]}];
        r_id <= r_imem[{r_bin, r_j[5:0]}];
        r_ad <= r_acc[r_j[5:0]];
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_accv <= '0;
            r_rv <= 1'b0;
            r_ovalid <= 1'b0;
            r_j <= '0;
        end else begin
            r_ovalid <= 1'b0;
            r_rv <= 1'b0;
            if (r_rv) begin
                r_acc[r_rj] <= (r_accv[r_rj] ? r_ad : 32'd0) ^ (r_ld & r_id);
                r_accv[r_rj] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    r_j <= '0;
                    r_n <= nw;
                    if (o_pop) begin
                        r_lvl <= i_job.lvl;
                        r_bin <= i_job.bin;
                        if (i_job.finish) begin
                            if (nw == 7'd0) r_accv <= '0;
                            else r_state <= S_FIN;
                        end else if (nw != 7'd0) begin
                            r_state <= S_PEAK;
                        end
                    end
                end
                S_PEAK: begin
                    r_rv <= 1'b1;
                    r_rj <= r_j[5:0];
                    r_j <= r_j + 7'd1;
                    if (r_j + 7'd1 == r_n) r_state <= S_IDLE;
                end
                S_FIN: begin
                    r_ovalid <= 1'b1;
                    r_oitem.out_index <= r_j[5:0];
                    r_oitem.out_word <= r_accv[r_j[5:0]] ? r_acc[r_j[5:0]] : 32'd0;
                    r_oitem.last <= (r_j + 7'd1 == r_n);
                    r_j <= r_j + 7'd1;
                    if (r_j + 7'd1 == r_n) begin
                        r_state <= S_IDLE;
                        r_accv <= '0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[src/hd_spectrum_encoder_top.sv]
// top level: hyperdimensional spectrum encoder
// a load is written on acceptance; it waits while a job is in the front, queued or walking
// a peak holds the front through multiply, a 16-step bin divider and push (stalls while
// the queue is full) and the back through pop, a walk over the words in use, final write
// a finish is pushed and queued like a peak, then gives its results one per cycle;
// the receiver cannot stall; synchronous active-low reset clears control, accumulator, config
`default_nettype none
module hd_spectrum_encoder_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire hdse_pkg::t_in_item  i_item,
    output logic                     o_strobe,
    output hdse_pkg::t_out_item      o_item,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [10:0]         i_cfg_data
);
    logic [5:0]  r_levels;
    logic [10:0] r_bin_width;
    logic [6:0]  r_words;
    logic        lwe, iwe, jv, full, empty, pop, tbusy;
    logic [15:0] waddr;
    logic [31:0] wdata;
    hdse_pkg::t_job job, qjob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= 6'd16;
            r_bin_width <= 11'd1;
            r_words <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hdse_pkg::CFG_LEVELS:    r_levels <= i_cfg_data[5:0];
                hdse_pkg::CFG_BIN_WIDTH: r_bin_width <= i_cfg_data;
                hdse_pkg::CFG_WORDS:     r_words <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    hdse_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_item(i_item),
        .o_busy(busy), .i_levels(r_levels), .i_bin_width(r_bin_width),
        .i_tables_busy(tbusy),
        .o_lwe(lwe), .o_iwe(iwe), .o_waddr(waddr), .o_wdata(wdata),
        .o_job_valid(jv), .o_job(job), .i_job_full(full)
    );

    hdse_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(jv), .i_data(job),
        .o_full(full), .i_pop(pop), .o_empty(empty), .o_data(qjob)
    );

    hdse_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_lwe(lwe), .i_iwe(iwe),
        .i_waddr(waddr), .i_wdata(wdata), .i_words(r_words),
        .i_empty(empty), .i_job(qjob), .o_pop(pop), .o_tables_busy(tbusy),
        .o_valid(o_strobe), .o_item(o_item)
    );
endmodule
`default_nettype wire
